[rtl/dmxr_pkg.sv]
// Package for the DMX512 slot receiver: item structs, receiver state codes,
// and default parameter values. Depends on nothing.
package dmxr_pkg;

	localparam int DMXR_NUM_CHANNELS = 4;
	localparam int DMXR_CNT_W = 10;
	localparam int DMXR_IDX_W = 6;

	localparam logic [DMXR_CNT_W-1:0] DMXR_START_ADDR_RST = DMXR_CNT_W'(1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       framing_error;
	} dmxr_in_t;

	typedef struct packed {
		logic                  capture_valid;
		logic [DMXR_IDX_W-1:0] slot_index;
		logic [7:0]            slot_value;
		logic                  frame_done;
	} dmxr_out_t;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'b0001,
		ST_BREAK   = 4'b0010,
		ST_COUNT   = 4'b0100,
		ST_CAPTURE = 4'b1000
	} dmxr_state_t;

	// Receiver state handed between the state registers and the decoder.
	typedef struct packed {
		dmxr_state_t           rx_state;
		logic [DMXR_CNT_W-1:0] slot_counter;
	} dmxr_ctl_t;

endpackage

[rtl/dmxr_decode.sv]
// Next-state and result logic for one received byte of the DMX512 slot receiver.
// Depends on dmxr_pkg.
module dmxr_decode import dmxr_pkg::*; #(
	parameter int NUM_CHANNELS = DMXR_NUM_CHANNELS
) (
	input  dmxr_ctl_t             ctl,
	input  logic [DMXR_CNT_W-1:0] start_address,
	input  dmxr_in_t              item,
	output dmxr_ctl_t             ctl_nxt,
	output dmxr_out_t             res
);

	logic [DMXR_CNT_W:0]   cnt_inc;
	logic [DMXR_CNT_W-1:0] cnt_dec;
	logic                  cap_last;
	logic                  first_last;

	assign cnt_inc    = {1'b0, ctl.slot_counter} + (DMXR_CNT_W+1)'(1);
	assign cnt_dec    = ctl.slot_counter - DMXR_CNT_W'(1);
	assign cap_last   = cnt_inc >= (DMXR_CNT_W+1)'(NUM_CHANNELS);
	assign first_last = (NUM_CHANNELS <= 1);

	always_comb begin
		res     = '0;
		ctl_nxt = ctl;
		if (ctl.rx_state == ST_CAPTURE) begin
			// Capture takes priority: a framing error here is ignored.
			res.capture_valid    = 1'b1;
			res.slot_index       = ctl.slot_counter[DMXR_IDX_W-1:0];
			res.slot_value       = item.data_byte;
			res.frame_done       = cap_last;
			ctl_nxt.slot_counter = cnt_inc[DMXR_CNT_W-1:0];
			if (cap_last) begin
				ctl_nxt.rx_state = ST_IDLE;
			end
		end else if (item.framing_error) begin
			ctl_nxt.slot_counter = start_address;
			ctl_nxt.rx_state     = ST_BREAK;
		end else begin
			case (ctl.rx_state)
				ST_BREAK: begin
					ctl_nxt.rx_state = (item.data_byte == 8'd0) ? ST_COUNT : ST_IDLE;
				end
				ST_COUNT: begin
					ctl_nxt.slot_counter = cnt_dec;
					if (cnt_dec == '0) begin
						res.capture_valid    = 1'b1;
						res.slot_value       = item.data_byte;
						res.frame_done       = first_last;
						ctl_nxt.slot_counter = DMXR_CNT_W'(1);
						ctl_nxt.rx_state     = first_last ? ST_IDLE : ST_CAPTURE;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/dmx512_slot_receiver_unit.sv]
// Top level of the DMX512 slot receiver: input stage, state and result registers.
// Depends on dmxr_pkg and dmxr_decode.
//
// Takes one UART byte per item with its framing-error flag (a framing error is
// the break) and returns exactly one result item per input item. After a break
// and a zero start code the receiver counts data slots down to start_address,
// then captures NUM_CHANNELS consecutive bytes, each reported with its 0-based
// channel index; the last one carries frame_done. Results with capture_valid low
// have all other fields zero. A break during capture is ignored. A nonzero start
// code, or the end of capture, returns the receiver to idle until the next break.
// Throughput is one item per clock while result_stall is low; an item passes
// the input register, then the decode into the result register. The input
// stage keeps accepting while a result waits at the output, so
// item_stall rises only when both registers are full and result_stall is high.
// start_address resets to 1 and is written through cfg_valid/cfg_data, which is
// always ready; write it only while no item is in flight, since the buffered item
// is decoded against the address held at the time it advances.
module dmx512_slot_receiver_unit import dmxr_pkg::*; #(
	parameter int NUM_CHANNELS = DMXR_NUM_CHANNELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  dmxr_in_t              item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output dmxr_out_t             result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [DMXR_CNT_W-1:0] cfg_data
);

	logic                  valid_s1;
	dmxr_in_t              item_s1;
	logic                  adv_s1;
	logic                  accept;
	logic                  result_valid_q;
	dmxr_out_t             result_q;
	dmxr_ctl_t             ctl_q;
	dmxr_ctl_t             ctl_nxt;
	dmxr_out_t             res_d;
	logic [DMXR_CNT_W-1:0] start_address_q;

	// Advance the input stage whenever the result register is empty or draining.
	assign adv_s1     = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !adv_s1;
	assign accept     = item_valid && !item_stall;
	assign cfg_ready  = 1'b1;

	// Hold the configured start address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_address_q <= DMXR_START_ADDR_RST;
		end else if (cfg_valid && cfg_ready) begin
			start_address_q <= cfg_data;
		end
	end

	// Input register: load a new item, or drop the old one once it has moved on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	dmxr_decode #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_decode (
		.ctl          (ctl_q),
		.start_address(start_address_q),
		.item         (item_s1),
		.ctl_nxt      (ctl_nxt),
		.res          (res_d)
	);

	// Receiver state moves only when the buffered item leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.rx_state     <= ST_IDLE;
			ctl_q.slot_counter <= '0;
		end else if (adv_s1) begin
			ctl_q <= ctl_nxt;
		end
	end

	// Result register: fill on advance, empty when the consumer takes the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// A stalled input means both registers hold items.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid_q))
		else $error("input stalled with a free register");

	// The last channel of a frame sends the receiver back to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && res_d.frame_done) |=> (ctl_q.rx_state == ST_IDLE))
		else $error("receiver not idle after frame done");

	// Non-captures carry zero fields, and frame_done only comes with a capture.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_q.capture_valid) |->
		(result_q.slot_index == '0 && result_q.slot_value == '0 && !result_q.frame_done))
		else $error("non-capture result carries data");

	// While capturing, the channel counter stays below the channel count.
	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q.rx_state == ST_CAPTURE) |->
		({1'b0, ctl_q.slot_counter} < (DMXR_CNT_W+1)'(NUM_CHANNELS)))
		else $error("channel counter out of range while capturing");

endmodule

[test/dmx512_slot_receiver_unit_checker.sv]
`timescale 1ns / 100ps
// Checker for the DMX512 slot receiver: watches the item, result and start-address
// channels, predicts each result and compares it. Depends on dmxr_pkg.
module dmx512_slot_receiver_unit_checker import dmxr_pkg::*; #(
	parameter int NUM_CHANNELS = DMXR_NUM_CHANNELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  item_stall,
	input  dmxr_in_t              item,
	input  logic                  result_valid,
	input  logic                  result_stall,
	input  dmxr_out_t             result,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [DMXR_CNT_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending_count
);

	dmxr_state_t           rx_mode;
	logic [DMXR_CNT_W-1:0] slot_count;
	logic [DMXR_CNT_W-1:0] first_slot;
	dmxr_out_t             slot_results[$];
	dmxr_out_t             want;

	// Advance the predicted receiver by one byte and return the result it gives.
	function automatic dmxr_out_t decode_slot(dmxr_in_t rx);
		dmxr_out_t res;
		res = '0;
		if (rx_mode == ST_CAPTURE) begin
			// capture wins over a framing error
			res.capture_valid = 1'b1;
			res.slot_index = slot_count[DMXR_IDX_W-1:0];
			res.slot_value = rx.data_byte;
			res.frame_done = (int'(slot_count) + 1 >= NUM_CHANNELS);
			slot_count = slot_count + 1'b1;
			if (res.frame_done)
				rx_mode = ST_IDLE;
		end else if (rx.framing_error) begin
			slot_count = first_slot;
			rx_mode = ST_BREAK;
		end else if (rx_mode == ST_BREAK) begin
			rx_mode = (rx.data_byte == 8'd0) ? ST_COUNT : ST_IDLE;
		end else if (rx_mode == ST_COUNT) begin
			slot_count = slot_count - 1'b1;
			if (slot_count == '0) begin
				res.capture_valid = 1'b1;
				res.slot_value = rx.data_byte;
				res.frame_done = (NUM_CHANNELS <= 1);
				slot_count = DMXR_CNT_W'(1);
				rx_mode = res.frame_done ? ST_IDLE : ST_CAPTURE;
			end
		end
		return res;
	endfunction

	task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0d, actual %0d", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_mode = ST_IDLE;
			slot_count = '0;
			first_slot = DMXR_START_ADDR_RST;
			slot_results.delete();
			pending_count = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (slot_results.size() == 0) begin
					$error("result item with no expectation waiting: %p", result);
					fail_count++;
				end else begin
					want = slot_results.pop_front();
					check_field("capture_valid", 16'(want.capture_valid),
						16'(result.capture_valid));
					check_field("slot_index", 16'(want.slot_index), 16'(result.slot_index));
					check_field("slot_value", 16'(want.slot_value), 16'(result.slot_value));
					check_field("frame_done", 16'(want.frame_done), 16'(result.frame_done));
				end
			end
			if (cfg_valid && cfg_ready)
				first_slot = cfg_data;
			if (item_valid && !item_stall)
				slot_results.push_back(decode_slot(item));
			pending_count = slot_results.size();
		end
	end

endmodule

[test/dmx512_slot_receiver_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the DMX512 slot receiver: drives bytes, stalls and start
// addresses, and gives the verdict. Depends on dmxr_pkg and the checker module.
module dmx512_slot_receiver_unit_tb;
	import dmxr_pkg::*;

	localparam int CHANNELS = DMXR_NUM_CHANNELS;
	localparam int IDLE_LIMIT = 5000;  // cycles with no handshake before giving up
	localparam int HOLD_CYCLES = 400;  // long receiver hold-off

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	dmxr_in_t              item = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	dmxr_out_t             result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [DMXR_CNT_W-1:0] cfg_data = '0;

	int fail_count;
	int pending_count;
	int bytes_sent = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;      // set: neither side inserts gaps
	bit hold_req = 1'b0;  // set by the sender, cleared by the receiver once served

	always #10 clk = ~clk;

	dmx512_slot_receiver_unit #(
		.NUM_CHANNELS(CHANNELS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	dmx512_slot_receiver_unit_checker #(
		.NUM_CHANNELS(CHANNELS)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	// Gap length: mostly none, often a few cycles, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one byte, after an optional gap, and hold it until the block takes it.
	// Valid stays high on return so back-to-back bytes need no toggle.
	task automatic send_byte(input logic [7:0] b, input logic fe);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{data_byte: b, framing_error: fe};
		do
			@(posedge clk);
		while (item_stall);
		bytes_sent++;
	endtask

	// Drop valid and wait until every predicted result has come back.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	task automatic write_start_address(input logic [DMXR_CNT_W-1:0] addr);
		cfg_valid <= 1'b1;
		cfg_data <= addr;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// One frame: break(s), a start code (usually zero), then data slots.
	// noise_pct is the chance of a framing error on each data slot.
	task automatic send_frame(input int slots, input int noise_pct);
		logic [7:0] code;
		repeat ($urandom_range(1, 2))
			send_byte(8'($urandom), 1'b1);
		code = ($urandom_range(0, 99) < 85) ? 8'h00 : 8'($urandom_range(1, 255));
		send_byte(code, 1'b0);
		repeat (slots)
			send_byte(8'($urandom), $urandom_range(0, 99) < noise_pct);
	endtask

	// Set a start address on an idle block, then run frames sized around it.
	// Frames end a little short of or past the captured window; with noise
	// enabled, short runs of random bytes are mixed in.
	task automatic run_phase(input int addr, input int n_bytes, input int spread,
			input int noise_pct);
		int goal;
		int need;
		int slots;
		drain();
		write_start_address(DMXR_CNT_W'(addr));
		goal = bytes_sent + n_bytes;
		need = ((addr == 0) ? 1024 : addr) - 1 + CHANNELS;
		do begin
			calm = ($urandom_range(0, 4) == 0);
			if (noise_pct > 0 && $urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom), $urandom_range(0, 3) == 0);
			end else begin
				slots = need - spread / 2 + $urandom_range(0, spread);
				send_frame((slots < 0) ? 0 : slots, noise_pct);
			end
		end while (bytes_sent < goal);
		calm = 1'b0;
	endtask

	// Receiver side: random stalls, none in calm stretches, and one long
	// hold-off when the sender asks for it.
	initial begin
		int gap;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm) begin
				gap = pick_gap();
				if (gap > 0) begin
					result_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
			end
			result_stall <= 1'b0;
			@(posedge clk);
		end
	end

	// Watchdog: end the run once nothing has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("dmx512_slot_receiver_unit_tb: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed bytes with the start address at its lowest, slot 1.
		write_start_address(DMXR_CNT_W'(1));
		send_byte(8'h00, 1'b0);  // bytes while idle capture nothing
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);  // break
		send_byte(8'h55, 1'b0);  // nonzero start code: back to idle
		send_byte(8'h00, 1'b0);  // still idle
		send_byte(8'h00, 1'b1);  // break
		send_byte(8'h00, 1'b0);  // start code zero
		send_byte(8'hFF, 1'b0);  // channel 0
		send_byte(8'h00, 1'b1);  // channel 1: break during capture is ignored
		send_byte(8'h80, 1'b0);  // channel 2
		send_byte(8'h01, 1'b0);  // channel 3, last of the frame
		send_byte(8'hA5, 1'b0);  // idle again until the next break
		send_byte(8'h3C, 1'b1);  // two breaks in a row
		send_byte(8'hC3, 1'b1);
		send_byte(8'h00, 1'b0);  // start code, now counting slots
		send_byte(8'h22, 1'b1);  // break while counting restarts the frame
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFE, 1'b1);  // last channel carrying a framing error
		send_byte(8'h00, 1'b1);
		send_byte(8'h01, 1'b0);  // start code one
		send_byte(8'h00, 1'b0);

		// Random frames over a spread of start addresses, the extremes included.
		run_phase($urandom_range(2, 8), 150, 6, 3);
		run_phase(512, 1, 2, 0);
		run_phase(0, 1, 0, 0);  // counter wraps: capture 1024 slots after start
		run_phase($urandom_range(13, 128), 1, 2, 0);
		repeat (3)
			run_phase($urandom_range(1, 12), 60, 6, 5);

		// Long receiver hold-off while bytes keep coming, so the input backs up.
		drain();
		hold_req = 1'b1;
		run_phase(2, 200, 4, 3);

		drain();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("dmx512_slot_receiver_unit_tb: PASS");
		else
			$display("dmx512_slot_receiver_unit_tb: FAIL");
		$finish;
	end

endmodule

[filelist.f]
rtl/dmxr_pkg.sv
rtl/dmxr_decode.sv
rtl/dmx512_slot_receiver_unit.sv
test/dmx512_slot_receiver_unit_checker.sv
test/dmx512_slot_receiver_unit_tb.sv
